>>> design/rsa_pkg.sv
// Package with the shared types and constants of the radius stop assignment block.
`timescale 1ns / 1ps

package rsa_pkg;

    localparam int COORD_W = 16;
    localparam int TAG_W   = 16;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int D2_W    = 33;
    localparam int DIST_W  = 17;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [COORD_W-1:0] RADIUS_RESET = 16'd5120;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] idx;
        logic [D2_W-1:0]  d2;
        logic             in_radius;
        logic             last;
    } cand_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> design/rsa_if.sv
// Handshake interfaces for the input item channel and the result channel.
`timescale 1ns / 1ps

interface rsa_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] student_id;

    modport source (output valid, mode, coord_x, coord_y, student_id, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, student_id, output ready);
endinterface

interface rsa_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] student_tag;
    logic [5:0]  stop_index;
    logic [16:0] walk_distance;
    logic        in_radius;
    logic        last;

    modport source (output valid, student_tag, stop_index, walk_distance, in_radius, last,
                    input ready);
    modport sink   (input valid, student_tag, stop_index, walk_distance, in_radius, last,
                    output ready);
endinterface

>>> design/rsa_queue.sv
// Short candidate queue between the scanning front end and the root back end.
`timescale 1ns / 1ps

module rsa_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rsa_pkg::cand_t push_data,
    input  logic           pop,
    output rsa_pkg::cand_t pop_data,
    output rsa_pkg::q_status_t status
);
    import rsa_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    cand_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (fill_reg == (PTR_W+1)'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= (PTR_W+1)'(DEPTH))
        else $error("Queue fill level beyond its depth.");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (do_push && !do_pop) |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("Queue fill level did not grow on a push.");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (do_pop && !do_push) |=> fill_reg == $past(fill_reg) - 1'b1)
        else $error("Queue fill level did not shrink on a pop.");

endmodule

>>> design/rsa_front.sv
// Front end: stop table, append and clear handling, and the pipelined distance scan.
`timescale 1ns / 1ps

module rsa_front #(
    parameter int MAX_STOPS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    rsa_item_if.sink           items,
    input  logic [15:0]        walk_radius,
    output logic               push,
    output rsa_pkg::cand_t     push_data,
    input  rsa_pkg::q_status_t q_status
);
    import rsa_pkg::*;

    localparam int ADDR_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

    typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [2*COORD_W-1:0] table_mem [MAX_STOPS];
    logic [CNT_W-1:0]     count_reg;
    logic [COORD_W-1:0]   px_reg;
    logic [COORD_W-1:0]   py_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [D2_W-1:0]      r2_reg;
    logic [CNT_W-1:0]     issue_idx_reg;
    logic                 issue_act_reg;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 fin1_reg, fin2_reg, fin3_reg, fin4_reg;
    logic [IDX_W-1:0]     idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [2*COORD_W-1:0] rd_reg;
    logic [COORD_W-1:0]   dx_reg, dy_reg;
    logic [2*COORD_W-1:0] sqx_reg, sqy_reg;
    logic [D2_W-1:0]      d2_reg;

    cand_t                pend_reg;
    logic                 pend_v_reg;
    logic [D2_W-1:0]      best_d2_reg;
    logic [IDX_W-1:0]     best_idx_reg;

    logic                 accept;
    logic                 hit;
    logic                 en;
    logic                 issue_fin;
    logic [COORD_W-1:0]   sx;
    logic [COORD_W-1:0]   sy;

    assign items.ready = (state_reg == IDLE);
    assign accept      = items.valid && items.ready;
    assign hit         = (d2_reg <= r2_reg);
    assign en          = !(v4_reg && hit && pend_v_reg && q_status.full);
    assign issue_fin   = (issue_idx_reg == count_reg - 1'b1);
    assign sx          = rd_reg[2*COORD_W-1:COORD_W];
    assign sy          = rd_reg[COORD_W-1:0];

    always_comb
    begin
        push      = 1'b0;
        push_data = pend_reg;
        case (state_reg)
            SCAN:
            begin
                push = v4_reg && hit && pend_v_reg;
            end
            FINISH:
            begin
                push = 1'b1;
                if (pend_v_reg)
                begin
                    push_data.last = 1'b1;
                end
                else
                begin
                    push_data.tag       = tag_reg;
                    push_data.idx       = best_idx_reg;
                    push_data.d2        = best_d2_reg;
                    push_data.in_radius = 1'b0;
                    push_data.last      = 1'b1;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (accept && items.mode == MODE_QUERY && count_reg != '0)
                begin
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (v4_reg && en && fin4_reg)
                begin
                    state_next = FINISH;
                end
            end
            FINISH:
            begin
                if (!q_status.full)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && items.mode == MODE_APPEND && count_reg < CNT_W'(MAX_STOPS))
        begin
            table_mem[count_reg[ADDR_W-1:0]] <= {items.coord_x, items.coord_y};
        end
        if (state_reg == SCAN && en)
        begin
            rd_reg <= table_mem[issue_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg  <= items.coord_x;
            py_reg  <= items.coord_y;
            tag_reg <= items.student_id;
            r2_reg  <= D2_W'({{COORD_W{1'b0}}, walk_radius} * {{COORD_W{1'b0}}, walk_radius});
        end
        if (en)
        begin
            idx1_reg <= issue_idx_reg[IDX_W-1:0];
            fin1_reg <= issue_fin;
            idx2_reg <= idx1_reg;
            fin2_reg <= fin1_reg;
            dx_reg   <= (px_reg >= sx) ? px_reg - sx : sx - px_reg;
            dy_reg   <= (py_reg >= sy) ? py_reg - sy : sy - py_reg;
            idx3_reg <= idx2_reg;
            fin3_reg <= fin2_reg;
            sqx_reg  <= {{COORD_W{1'b0}}, dx_reg} * {{COORD_W{1'b0}}, dx_reg};
            sqy_reg  <= {{COORD_W{1'b0}}, dy_reg} * {{COORD_W{1'b0}}, dy_reg};
            idx4_reg <= idx3_reg;
            fin4_reg <= fin3_reg;
            d2_reg   <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
        if (state_reg == SCAN && v4_reg && en)
        begin
            if (idx4_reg == '0 || d2_reg < best_d2_reg)
            begin
                best_d2_reg  <= d2_reg;
                best_idx_reg <= idx4_reg;
            end
            if (hit)
            begin
                pend_reg.tag       <= tag_reg;
                pend_reg.idx       <= idx4_reg;
                pend_reg.d2        <= d2_reg;
                pend_reg.in_radius <= 1'b1;
                pend_reg.last      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            issue_act_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            pend_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && items.mode == MODE_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (accept && items.mode == MODE_APPEND && count_reg < CNT_W'(MAX_STOPS))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == IDLE)
            begin
                issue_idx_reg <= '0;
                issue_act_reg <= accept && items.mode == MODE_QUERY && count_reg != '0;
                pend_v_reg    <= 1'b0;
                v1_reg        <= 1'b0;
                v2_reg        <= 1'b0;
                v3_reg        <= 1'b0;
                v4_reg        <= 1'b0;
            end
            else if (state_reg == SCAN && en)
            begin
                v1_reg <= issue_act_reg;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                if (issue_act_reg)
                begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                    if (issue_fin)
                    begin
                        issue_act_reg <= 1'b0;
                    end
                end
                if (v4_reg && hit)
                begin
                    pend_v_reg <= 1'b1;
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> state_reg != IDLE)
        else $error("Candidate pushed while no query is running.");
    assert property (@(posedge clk) disable iff (!rst_n)
                     issue_act_reg |-> issue_idx_reg < count_reg)
        else $error("Scan issued an index beyond the stored stops.");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == FINISH && !q_status.full) |=> state_reg == IDLE)
        else $error("Query did not close after its final result.");

endmodule

>>> design/rsa_back.sv
// Back end: bit-serial square root of each candidate and the result output register.
`timescale 1ns / 1ps

module rsa_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  rsa_pkg::cand_t     pop_data,
    input  rsa_pkg::q_status_t q_status,
    output logic               pop,
    rsa_result_if.source       results
);
    import rsa_pkg::*;

    typedef enum logic [1:0] {IDLE, ROOT, HOLD} state_t;

    localparam int STEPS = DIST_W;

    state_t              state_reg;
    logic [2*STEPS-1:0]  val_reg;
    logic [DIST_W+1:0]   rem_reg;
    logic [DIST_W-1:0]   root_reg;
    logic [4:0]          step_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                inr_reg;
    logic                last_reg;
    logic                ov_reg;
    logic [DIST_W+3:0]   shifted;
    logic [DIST_W+3:0]   trial;
    logic                take;
    logic                load;

    assign pop     = (state_reg == IDLE) && !q_status.empty;
    assign shifted = {rem_reg, val_reg[2*STEPS-1:2*STEPS-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign take    = (shifted >= trial);
    assign load    = (state_reg == HOLD) && (!ov_reg || results.ready);
    assign results.valid = ov_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            val_reg  <= {1'b0, pop_data.d2};
            rem_reg  <= '0;
            root_reg <= '0;
            tag_reg  <= pop_data.tag;
            idx_reg  <= pop_data.idx;
            inr_reg  <= pop_data.in_radius;
            last_reg <= pop_data.last;
        end
        else if (state_reg == ROOT)
        begin
            val_reg <= {val_reg[2*STEPS-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= (DIST_W+2)'(shifted - trial);
                root_reg <= {root_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[DIST_W+1:0];
                root_reg <= {root_reg[DIST_W-2:0], 1'b0};
            end
        end
        if (load)
        begin
            results.student_tag   <= tag_reg;
            results.stop_index    <= idx_reg;
            results.walk_distance <= root_reg;
            results.in_radius     <= inr_reg;
            results.last          <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    step_reg <= '0;
                    if (pop)
                    begin
                        state_reg <= ROOT;
                    end
                end
                ROOT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'(STEPS - 1))
                    begin
                        state_reg <= HOLD;
                    end
                end
                HOLD:
                begin
                    if (load)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |=> state_reg == ROOT)
        else $error("Root unit did not start after taking a candidate.");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (ov_reg && !results.ready) |=> ov_reg)
        else $error("Result dropped while stalled.");
    assert property (@(posedge clk) disable iff (!rst_n)
                     state_reg == ROOT |-> step_reg < 5'(STEPS))
        else $error("Root step count overran.");

endmodule

>>> design/radius_stop_assignment_unit.sv
// Top level of the radius stop assignment block: radius register, front end, queue, back end.
// Clear and append each complete in a single handshake; a query holds the input
// while the front end scans its n stored stops through a four-stage distance pipeline.
// Each result then passes through the bit-serial square root unit before it reaches
// the output register; the root unit takes the next candidate only after that load.
// Reset is asynchronous and active low; it empties the stop table and sets the radius to 20.0.
`timescale 1ns / 1ps

module radius_stop_assignment_unit #(
    parameter int MAX_STOPS = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    rsa_item_if.sink      items,
    rsa_result_if.source  results,
    input  logic          wr_en,
    input  logic [15:0]   wr_data
);
    import rsa_pkg::*;

    logic [15:0] walk_radius_reg;
    logic        push;
    logic        pop;
    cand_t       push_data;
    cand_t       pop_data;
    q_status_t   q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_radius_reg <= RADIUS_RESET;
        end
        else if (wr_en)
        begin
            walk_radius_reg <= wr_data;
        end
    end

    rsa_front #(.MAX_STOPS(MAX_STOPS)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .walk_radius (walk_radius_reg),
        .push        (push),
        .push_data   (push_data),
        .q_status    (q_status)
    );

    rsa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    rsa_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .q_status (q_status),
        .pop      (pop),
        .results  (results)
    );

endmodule
